/* rtl/pipf_pkg.sv */
// Package for the point-into-pose-frame core: beat types and fixed-point constants.
// No dependencies; imported by rtl/point_into_pose_frame_core.sv, dv/local_point_checker.sv and the testbench top.

package pipf_pkg;

   // Request beat: frame origin (Q16.16), frame quaternion (Q1.30), world point (Q16.16).
   typedef struct packed {
      logic signed [31:0] frame_x;
      logic signed [31:0] frame_y;
      logic signed [31:0] frame_z;
      logic signed [31:0] base_qx;
      logic signed [31:0] base_qy;
      logic signed [31:0] base_qz;
      logic signed [31:0] base_qw;
      logic signed [31:0] obj_x;
      logic signed [31:0] obj_y;
      logic signed [31:0] obj_z;
   } pipf_req_type;

   // Response beat: point in the frame, Q16.16, saturated.
   typedef struct packed {
      logic signed [31:0] local_x;
      logic signed [31:0] local_y;
      logic signed [31:0] local_z;
   } pipf_rsp_type;

   // Quaternion pair-product slots.
   localparam int PROD_XX = 0;
   localparam int PROD_YY = 1;
   localparam int PROD_ZZ = 2;
   localparam int PROD_XY = 3;
   localparam int PROD_XZ = 4;
   localparam int PROD_YZ = 5;
   localparam int PROD_XW = 6;
   localparam int PROD_YW = 7;
   localparam int PROD_ZW = 8;
   localparam int NUM_PROD = 9;

   // Rounding offsets for the Q.60 -> Q.30 and Q.46 -> Q.16 shifts.
   localparam logic signed [63:0] QUAT_HALF = 64'sd536870912;
   localparam logic signed [64:0] TERM_HALF = 65'sd536870912;

   // Rotation entry limits (Q1.30 one) in the wide and the stored width.
   localparam logic signed [37:0] ROT_ONE_WIDE   = 38'sd1073741824;
   localparam logic signed [37:0] ROT_MIN_WIDE   = -38'sd1073741824;
   localparam logic signed [31:0] ROT_ONE        = 32'sd1073741824;
   localparam logic signed [31:0] ROT_MIN        = -32'sd1073741824;

   // Q16.16 result limits.
   localparam logic signed [36:0] OUT_MAX_WIDE = 37'sd2147483647;
   localparam logic signed [36:0] OUT_MIN_WIDE = -37'sd2147483648;
   localparam logic signed [31:0] OUT_MAX      = 32'sh7FFF_FFFF;
   localparam logic signed [31:0] OUT_MIN      = 32'sh8000_0000;

endpackage

/* rtl/point_into_pose_frame_core.sv */
// Point-into-pose-frame core: R^T * (point - origin) with R built from a quaternion.
// Depends on rtl/pipf_pkg.sv for beat types and constants.
//
// Pipeline: a beat accepted at one clock edge reaches rsp_* through four register stages
// (pair products, rotation matrix, matrix terms, sum/saturate).
// Throughput: one beat per cycle; busy is low except while reset is high.
// The response side cannot stall, so no beat is ever held back inside the pipeline.
// Reset (synchronous, active high) clears the stage valid bits; in-flight beats are dropped.

module point_into_pose_frame_core (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   output logic                   busy,
   input  pipf_pkg::pipf_req_type req_item,
   output logic                   rsp_valid,
   output pipf_pkg::pipf_rsp_type rsp_item
);
   import pipf_pkg::*;

   logic accept;

   // stage 1: point offset and quaternion pair products
   logic                      s1_valid_ff, s1_valid_in;
   logic signed [32:0]        s1_d_ff    [3];
   logic signed [32:0]        s1_d_in    [3];
   logic signed [63:0]        s1_prod_ff [NUM_PROD];
   logic signed [63:0]        s1_prod_in [NUM_PROD];

   // stage 2: clamped rotation matrix, row-major
   logic                      s2_valid_ff, s2_valid_in;
   logic signed [32:0]        s2_d_ff    [3];
   logic signed [31:0]        s2_rot_ff  [9];
   logic signed [31:0]        s2_rot_in  [9];

   // stage 3: terms R[k][i] * d[k], slot 3*i+k
   logic                      s3_valid_ff, s3_valid_in;
   logic signed [64:0]        s3_term_ff [9];
   logic signed [64:0]        s3_term_in [9];

   // stage 4: output register
   logic                      s4_valid_ff, s4_valid_in;
   logic signed [31:0]        s4_out_ff  [3];
   logic signed [31:0]        s4_out_in  [3];

   // Refuse beats while reset is high.
   assign busy   = reset;
   assign accept = start && !busy;

   function automatic logic signed [31:0] clamp_rot(input logic signed [37:0] v);
      logic signed [31:0] r;
      if (v > ROT_ONE_WIDE) begin
         r = ROT_ONE;
      end else if (v < ROT_MIN_WIDE) begin
         r = ROT_MIN;
      end else begin
         r = v[31:0];
      end
      return r;
   endfunction

   function automatic logic signed [37:0] widen34(input logic signed [33:0] v);
      return $signed({{4{v[33]}}, v});
   endfunction

   // Stage 1: subtract origin, form the nine quaternion products.
   always_comb begin
      s1_valid_in = accept;
      s1_d_in[0]  = $signed({req_item.obj_x[31], req_item.obj_x})
                  - $signed({req_item.frame_x[31], req_item.frame_x});
      s1_d_in[1]  = $signed({req_item.obj_y[31], req_item.obj_y})
                  - $signed({req_item.frame_y[31], req_item.frame_y});
      s1_d_in[2]  = $signed({req_item.obj_z[31], req_item.obj_z})
                  - $signed({req_item.frame_z[31], req_item.frame_z});
      s1_prod_in[PROD_XX] = req_item.base_qx * req_item.base_qx;
      s1_prod_in[PROD_YY] = req_item.base_qy * req_item.base_qy;
      s1_prod_in[PROD_ZZ] = req_item.base_qz * req_item.base_qz;
      s1_prod_in[PROD_XY] = req_item.base_qx * req_item.base_qy;
      s1_prod_in[PROD_XZ] = req_item.base_qx * req_item.base_qz;
      s1_prod_in[PROD_YZ] = req_item.base_qy * req_item.base_qz;
      s1_prod_in[PROD_XW] = req_item.base_qx * req_item.base_qw;
      s1_prod_in[PROD_YW] = req_item.base_qy * req_item.base_qw;
      s1_prod_in[PROD_ZW] = req_item.base_qz * req_item.base_qw;
   end

   // Stage 2: round products to Q.30, build and clamp the rotation matrix.
   always_comb begin
      logic signed [63:0] biased;
      logic signed [33:0] rq [NUM_PROD];
      logic signed [37:0] e  [9];
      s2_valid_in = s1_valid_ff;
      for (int j = 0; j < NUM_PROD; j++) begin
         biased = s1_prod_ff[j] + QUAT_HALF;
         rq[j]  = $signed(biased[63:30]);
      end
      e[0] = ROT_ONE_WIDE - ((widen34(rq[PROD_YY]) + widen34(rq[PROD_ZZ])) <<< 1);
      e[1] = (widen34(rq[PROD_XY]) - widen34(rq[PROD_ZW])) <<< 1;
      e[2] = (widen34(rq[PROD_XZ]) + widen34(rq[PROD_YW])) <<< 1;
      e[3] = (widen34(rq[PROD_XY]) + widen34(rq[PROD_ZW])) <<< 1;
      e[4] = ROT_ONE_WIDE - ((widen34(rq[PROD_XX]) + widen34(rq[PROD_ZZ])) <<< 1);
      e[5] = (widen34(rq[PROD_YZ]) - widen34(rq[PROD_XW])) <<< 1;
      e[6] = (widen34(rq[PROD_XZ]) - widen34(rq[PROD_YW])) <<< 1;
      e[7] = (widen34(rq[PROD_YZ]) + widen34(rq[PROD_XW])) <<< 1;
      e[8] = ROT_ONE_WIDE - ((widen34(rq[PROD_XX]) + widen34(rq[PROD_YY])) <<< 1);
      for (int j = 0; j < 9; j++) begin
         s2_rot_in[j] = clamp_rot(e[j]);
      end
   end

   // Stage 3: multiply transposed matrix entries by the offset.
   always_comb begin
      s3_valid_in = s2_valid_ff;
      for (int i = 0; i < 3; i++) begin
         for (int k = 0; k < 3; k++) begin
            s3_term_in[3*i+k] = s2_rot_ff[3*k+i] * s2_d_ff[k];
         end
      end
   end

   // Stage 4: round terms to Q16.16, sum each row, saturate.
   always_comb begin
      logic signed [64:0] biased;
      logic signed [34:0] rt [9];
      logic signed [36:0] acc;
      s4_valid_in = s3_valid_ff;
      for (int j = 0; j < 9; j++) begin
         biased = s3_term_ff[j] + TERM_HALF;
         rt[j]  = $signed(biased[64:30]);
      end
      for (int i = 0; i < 3; i++) begin
         acc = $signed({{2{rt[3*i][34]}},   rt[3*i]})
             + $signed({{2{rt[3*i+1][34]}}, rt[3*i+1]})
             + $signed({{2{rt[3*i+2][34]}}, rt[3*i+2]});
         if (acc > OUT_MAX_WIDE) begin
            s4_out_in[i] = OUT_MAX;
         end else if (acc < OUT_MIN_WIDE) begin
            s4_out_in[i] = OUT_MIN;
         end else begin
            s4_out_in[i] = acc[31:0];
         end
      end
   end

   // Advance the valid bits; clear them on reset.
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
         s4_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s2_valid_in;
         s3_valid_ff <= s3_valid_in;
         s4_valid_ff <= s4_valid_in;
      end
   end

   // Advance the payload every cycle.
   always_ff @(posedge clock) begin
      s1_d_ff    <= s1_d_in;
      s1_prod_ff <= s1_prod_in;
      s2_d_ff    <= s1_d_ff;
      s2_rot_ff  <= s2_rot_in;
      s3_term_ff <= s3_term_in;
      s4_out_ff  <= s4_out_in;
   end

   // Drive the response beat.
   assign rsp_valid        = s4_valid_ff;
   assign rsp_item.local_x = s4_out_ff[0];
   assign rsp_item.local_y = s4_out_ff[1];
   assign rsp_item.local_z = s4_out_ff[2];

`ifndef NO_ASSERTIONS
   // Every accepted beat comes out of the four register stages, and nothing else does.
   assert property (@(posedge clock) disable iff (reset)
      (!$past(reset, 1) && !$past(reset, 2) && !$past(reset, 3) && !$past(reset, 4))
      |-> (rsp_valid == $past(accept, 4)))
      else $error("response strobe does not follow accepted beat by four cycles");

   // Zero XX, YY, ZZ, XY, ZW products give a unit diagonal and zero entries 1 and 3.
   assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && s1_prod_ff[PROD_XX] == '0 && s1_prod_ff[PROD_YY] == '0 &&
       s1_prod_ff[PROD_ZZ] == '0 && s1_prod_ff[PROD_XY] == '0 &&
       s1_prod_ff[PROD_ZW] == '0)
      |=> (s2_rot_ff[0] == ROT_ONE && s2_rot_ff[4] == ROT_ONE &&
           s2_rot_ff[8] == ROT_ONE && s2_rot_ff[1] == '0 && s2_rot_ff[3] == '0))
      else $error("zero quaternion did not give the identity rotation");

   // A point at the frame origin maps to zero in every axis.
   assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && s1_d_ff[0] == '0 && s1_d_ff[1] == '0 && s1_d_ff[2] == '0)
      |-> ##3 (rsp_valid && rsp_item == '0))
      else $error("point at frame origin did not map to zero");
`endif

endmodule

/* dv/local_point_checker.sv */
// Checker for point_into_pose_frame_core: predicts each local point and compares results.
// Depends on rtl/pipf_pkg.sv for the beat types; instantiated by dv/tb_point_into_pose_frame_core.sv.

module local_point_checker (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   input  logic                   busy,
   input  pipf_pkg::pipf_req_type req_item,
   input  logic                   rsp_valid,
   input  pipf_pkg::pipf_rsp_type rsp_item,
   output int                     fail_count,
   output int                     waiting
);
   timeunit 1ns;
   timeprecision 1ps;
   import pipf_pkg::*;

   localparam longint Q30_UNIT = 64'sd1073741824;
   localparam longint Q30_HALF = 64'sd536870912;
   localparam longint LOCAL_MAX = 64'sd2147483647;
   localparam longint LOCAL_MIN = -64'sd2147483648;

   pipf_rsp_type expected_local_q[$];
   pipf_rsp_type want;
   int           errs = 0;
   int           n_queued = 0;

   assign fail_count = errs;
   assign waiting    = n_queued;

   // Round a Q.60 or Q.46 product down to Q.30 or Q.16, half up.
   function automatic longint round_q30(longint p);
      return (p + Q30_HALF) >>> 30;
   endfunction

   function automatic longint clip(longint v, longint lo, longint hi);
      if (v < lo) return lo;
      if (v > hi) return hi;
      return v;
   endfunction

   // Point in the frame: R^T * (point - origin), R from the unnormalized quaternion.
   function automatic pipf_rsp_type to_frame_local(pipf_req_type b);
      longint qx, qy, qz, qw;
      longint xx, yy, zz, xy, xz, yz, xw, yw, zw;
      longint delta [3];
      longint rot [3][3];
      longint acc [3];
      pipf_rsp_type r;
      qx = longint'($signed(b.base_qx));
      qy = longint'($signed(b.base_qy));
      qz = longint'($signed(b.base_qz));
      qw = longint'($signed(b.base_qw));
      delta[0] = longint'($signed(b.obj_x)) - longint'($signed(b.frame_x));
      delta[1] = longint'($signed(b.obj_y)) - longint'($signed(b.frame_y));
      delta[2] = longint'($signed(b.obj_z)) - longint'($signed(b.frame_z));

      xx = round_q30(qx * qx);
      yy = round_q30(qy * qy);
      zz = round_q30(qz * qz);
      xy = round_q30(qx * qy);
      xz = round_q30(qx * qz);
      yz = round_q30(qy * qz);
      xw = round_q30(qx * qw);
      yw = round_q30(qy * qw);
      zw = round_q30(qz * qw);

      rot[0][0] = Q30_UNIT - 2 * (yy + zz);
      rot[0][1] = 2 * (xy - zw);
      rot[0][2] = 2 * (xz + yw);
      rot[1][0] = 2 * (xy + zw);
      rot[1][1] = Q30_UNIT - 2 * (xx + zz);
      rot[1][2] = 2 * (yz - xw);
      rot[2][0] = 2 * (xz - yw);
      rot[2][1] = 2 * (yz + xw);
      rot[2][2] = Q30_UNIT - 2 * (xx + yy);

      // Saturate matrix entries to +-1.0, then take the transposed product.
      for (int i = 0; i < 3; i++)
         for (int k = 0; k < 3; k++)
            rot[i][k] = clip(rot[i][k], -Q30_UNIT, Q30_UNIT);
      for (int i = 0; i < 3; i++) begin
         acc[i] = 0;
         for (int k = 0; k < 3; k++)
            acc[i] += round_q30(rot[k][i] * delta[k]);
         acc[i] = clip(acc[i], LOCAL_MIN, LOCAL_MAX);
      end
      r.local_x = acc[0][31:0];
      r.local_y = acc[1][31:0];
      r.local_z = acc[2][31:0];
      return r;
   endfunction

   task automatic report_mismatch(string msg);
      $display("ERROR %0t ns: %s", $time, msg);
      errs++;
   endtask

   // Compare each result beat with the oldest prediction, then log accepted requests.
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid) begin
            if (expected_local_q.size() == 0) begin
               report_mismatch("result beat with no request outstanding");
            end else begin
               want = expected_local_q.pop_front();
               if (rsp_item.local_x !== want.local_x)
                  report_mismatch($sformatf("local_x got %0d want %0d",
                                            rsp_item.local_x, want.local_x));
               if (rsp_item.local_y !== want.local_y)
                  report_mismatch($sformatf("local_y got %0d want %0d",
                                            rsp_item.local_y, want.local_y));
               if (rsp_item.local_z !== want.local_z)
                  report_mismatch($sformatf("local_z got %0d want %0d",
                                            rsp_item.local_z, want.local_z));
            end
         end
         if (start && !busy)
            expected_local_q.push_back(to_frame_local(req_item));
         n_queued = expected_local_q.size();
      end
   end

endmodule

/* dv/tb_point_into_pose_frame_core.sv */
// Top of the point_into_pose_frame_core testbench: clock, reset, request stimulus, verdict.
// Depends on rtl/pipf_pkg.sv, rtl/point_into_pose_frame_core.sv and dv/local_point_checker.sv.

module tb_point_into_pose_frame_core;
   timeunit 1ns;
   timeprecision 1ps;
   import pipf_pkg::*;

   localparam int Q30 = 1073741824;
   localparam int Q29 = 536870912;
   localparam int COS45 = 759250125;
   localparam int POS_MAX = 32'sh7FFF_FFFF;
   localparam int POS_MIN = 32'sh8000_0000;
   localparam int RANDOM_BEATS = 1900;
   localparam int CALM_TAIL = 300;

   logic         clock;
   logic         reset = 1'b1;
   logic         start = 1'b0;
   logic         busy;
   pipf_req_type req_item = '0;
   logic         rsp_valid;
   pipf_rsp_type rsp_item;
   logic         busy_seen = 1'b1;
   int           waiting_seen = 0;
   int           fail_count;
   int           waiting;

   point_into_pose_frame_core dut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_item  (req_item),
      .rsp_valid (rsp_valid),
      .rsp_item  (rsp_item)
   );

   local_point_checker checker_i (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_item   (req_item),
      .rsp_valid  (rsp_valid),
      .rsp_item   (rsp_item),
      .fail_count (fail_count),
      .waiting    (waiting)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // Sample handshake and drain state mid-cycle, away from the driving edge.
   always @(negedge clock) begin
      busy_seen    = busy;
      waiting_seen = waiting;
   end

   function automatic pipf_req_type make_beat(int fx, int fy, int fz, int qx, int qy, int qz,
                                              int qw, int ox, int oy, int oz);
      pipf_req_type b;
      b.frame_x = fx; b.frame_y = fy; b.frame_z = fz;
      b.base_qx = qx; b.base_qy = qy; b.base_qz = qz; b.base_qw = qw;
      b.obj_x = ox; b.obj_y = oy; b.obj_z = oz;
      return b;
   endfunction

   // Quaternion component across its whole legal range, with extremes mixed in.
   function automatic int rand_quat_comp();
      case ($urandom_range(0, 9))
         0: return Q30;
         1: return -Q30;
         2: return 0;
         3: return $urandom_range(0, 1) ? Q29 : -Q29;
         default: return int'(longint'($urandom_range(0, 32'h8000_0000)) - Q30);
      endcase
   endfunction

   // Position: full range, small metric values, or an extreme.
   function automatic int rand_position();
      case ($urandom_range(0, 9))
         0: return $urandom_range(0, 1) ? POS_MAX : POS_MIN;
         1, 2, 3, 4: return $urandom;
         default: return int'(longint'($urandom_range(0, 13107200)) - 6553600);
      endcase
   endfunction

   function automatic pipf_req_type rand_beat();
      pipf_req_type b;
      real a [4];
      real norm;
      b.frame_x = rand_position();
      b.frame_y = rand_position();
      b.frame_z = rand_position();
      b.obj_x = rand_position();
      b.obj_y = rand_position();
      b.obj_z = rand_position();
      if ($urandom_range(0, 9) < 7) begin
         // Mostly unit quaternions, as real poses carry.
         for (int i = 0; i < 4; i++)
            a[i] = real'($urandom_range(0, 2000000)) / 1.0e6 - 1.0;
         norm = $sqrt(a[0] * a[0] + a[1] * a[1] + a[2] * a[2] + a[3] * a[3]);
         if (norm < 1.0e-3) begin
            a[0] = 0.0; a[1] = 0.0; a[2] = 0.0; a[3] = 1.0; norm = 1.0;
         end
         b.base_qx = $rtoi(a[0] / norm * 1073741824.0);
         b.base_qy = $rtoi(a[1] / norm * 1073741824.0);
         b.base_qz = $rtoi(a[2] / norm * 1073741824.0);
         b.base_qw = $rtoi(a[3] / norm * 1073741824.0);
      end else begin
         b.base_qx = rand_quat_comp();
         b.base_qy = rand_quat_comp();
         b.base_qz = rand_quat_comp();
         b.base_qw = rand_quat_comp();
      end
      // Point at the origin now and then, so the difference is zero.
      if ($urandom_range(0, 31) == 0) begin
         b.obj_x = b.frame_x; b.obj_y = b.frame_y; b.obj_z = b.frame_z;
      end
      return b;
   endfunction

   // Hold start high with the beat until the core takes it.
   task automatic push_beat(pipf_req_type b);
      start    <= 1'b1;
      req_item <= b;
      @(posedge clock);
      while (busy_seen) @(posedge clock);
   endtask

   // Drop start for a short burst, with junk on the request bus.
   task automatic idle_burst();
      start    <= 1'b0;
      req_item <= {$urandom, $urandom, $urandom, $urandom, $urandom,
                   $urandom, $urandom, $urandom, $urandom, $urandom};
      repeat ($urandom_range(1, 4)) @(posedge clock);
   endtask

   task automatic send_beat(pipf_req_type b, bit gaps_on);
      if (gaps_on && $urandom_range(0, 2) == 0) idle_burst();
      push_beat(b);
   endtask

   initial begin
      pipf_req_type directed [$];
      bit gaps_on;
      int drain_cycles;

      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: identity, zero quaternion, extremes, quarter and half turns.
      directed.push_back(make_beat(0, 0, 0, 0, 0, 0, Q30, 65536, -65536, 131072));
      directed.push_back(make_beat(0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
      directed.push_back(make_beat(POS_MIN, POS_MIN, POS_MIN, 0, 0, 0, 0,
                                   POS_MAX, POS_MAX, POS_MAX));
      directed.push_back(make_beat(POS_MAX, POS_MAX, POS_MAX, 0, 0, 0, 0,
                                   POS_MIN, POS_MIN, POS_MIN));
      directed.push_back(make_beat(0, 0, 0, 0, 0, 0, Q30, POS_MAX, POS_MIN, POS_MAX));
      directed.push_back(make_beat(0, 0, 0, 0, 0, 0, -Q30, 1, -1, 12345));
      directed.push_back(make_beat(65536, 0, 0, 0, 0, COS45, COS45, 131072, 65536, 0));
      directed.push_back(make_beat(0, 0, 0, COS45, 0, 0, -COS45, 0, 65536, 65536));
      directed.push_back(make_beat(0, 0, 0, Q30, 0, 0, 0, 65536, 65536, 65536));
      directed.push_back(make_beat(0, 0, 0, 0, Q30, 0, 0, 65536, 65536, 65536));
      directed.push_back(make_beat(0, 0, 0, 0, 0, Q30, 0, 65536, 65536, 65536));
      directed.push_back(make_beat(0, 0, 0, Q29, Q29, Q29, Q29, 65536, 0, 0));
      directed.push_back(make_beat(POS_MIN, POS_MIN, POS_MIN, Q29, Q29, Q29, Q29,
                                   POS_MAX, POS_MAX, POS_MAX));
      directed.push_back(make_beat(POS_MAX, 0, POS_MIN, -Q29, Q29, -Q29, Q29,
                                   POS_MIN, 0, POS_MAX));
      directed.push_back(make_beat(1, 2, 3, Q30, Q30, Q30, Q30, 100, 200, 300));
      directed.push_back(make_beat(-7, 9, 4, -Q30, -Q30, -Q30, -Q30,
                                   POS_MAX, POS_MIN, 0));
      directed.push_back(make_beat(0, 0, 0, Q30, -Q30, Q30, -Q30,
                                   POS_MIN, POS_MAX, POS_MIN));
      directed.push_back(make_beat(POS_MAX, POS_MIN, 0, Q30, Q30, 0, 0,
                                   POS_MIN, POS_MAX, 0));
      directed.push_back(make_beat(1234567, -7654321, 42, 1, -1, 1, Q30,
                                   1234567, -7654321, 42));
      directed.push_back(make_beat(-1, -1, -1, -1, -1, -1, -1, -1, -1, -1));
      foreach (directed[i]) send_beat(directed[i], i % 3 == 1);

      // Random: phases with and without gaps, then a calm tail at full rate.
      gaps_on = 1'b1;
      for (int n = 0; n < RANDOM_BEATS; n++) begin
         if (n % 150 == 0) gaps_on = ($urandom_range(0, 2) != 0);
         if (n >= RANDOM_BEATS - CALM_TAIL) gaps_on = 1'b0;
         send_beat(rand_beat(), gaps_on);
      end
      start <= 1'b0;

      // Drain the pipeline, then let it settle before the verdict.
      drain_cycles = 0;
      @(negedge clock);
      while (waiting_seen != 0 && drain_cycles < 100) begin
         @(negedge clock);
         drain_cycles++;
      end
      repeat (8) @(posedge clock);
      @(negedge clock);

      if (fail_count == 0 && waiting_seen == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

   // Watchdog well beyond the slowest legal run.
   initial begin
      #2000000;
      $display("simulation failed");
      $finish;
   end

endmodule
